>>> rtl/csba_pkg.sv
// ----------------------------------------------------------------------------
// csba_pkg
// Shared types and constants for the compacting slot block allocator.
// ----------------------------------------------------------------------------
package csba_pkg;

  localparam int unsigned MAX_BLOCKS   = 1024;
  localparam int unsigned MAX_SLOTS    = 16;
  localparam int unsigned BLOCK_BYTES  = 16;
  localparam int unsigned HEADER_BYTES = 4;

  localparam int unsigned AW   = $clog2(MAX_BLOCKS);   // block address bits
  localparam int unsigned SZW  = AW + 1;               // size field bits
  localparam int unsigned PW   = AW + 2;               // walk pointer bits
  localparam int unsigned SLW  = $clog2(MAX_SLOTS);    // slot id bits
  localparam int unsigned SCW  = SLW + 1;              // slot count bits
  localparam int unsigned OFW  = 14;                   // payload offset bits
  localparam int unsigned BSH  = $clog2(BLOCK_BYTES);  // block byte shift

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_LOCATE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_SPACE  = 3'd1,
    ST_NO_SLOT   = 3'd2,
    ST_CORRUPT   = 3'd3,
    ST_BAD_SLOT  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CFG_TOTAL_BLOCKS = 2'd0,
    CFG_SLOT_COUNT   = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [SZW-1:0] size;
    logic           valid;
    logic [SLW-1:0] slot;
  } hdr_t;

endpackage

>>> rtl/compacting_slot_block_allocator.sv
// Locate answers from the slot table; free reads and rewrites one header; clear sweeps all headers.
// Alloc: first-fit walk over the headers with merge of free runs; if nothing fits, defrag slides
// valid entries down, emitting move orders, then rebuilds the slot table in a fixup pass.
// One command at a time on the header memory; in_ready_o is high only in idle.
// Result beats leave through an output register. Reset clears control state and the slot
// table; header entry 0 reads as a free entry of MAX_BLOCKS blocks until written.
// ----------------------------------------------------------------------------
// compacting_slot_block_allocator
// Block buffer allocator with in-line headers, first fit, merge, split and
// defragmentation move orders, driven by a small sequencer.
// ----------------------------------------------------------------------------
module compacting_slot_block_allocator
  import csba_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [13:0] alloc_bytes_i,
  input  logic [3:0]  slot_id_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [3:0]  result_slot_o,
  output logic [13:0] payload_offset_o,
  output logic        is_move_o,
  output logic [9:0]  move_from_o,
  output logic [9:0]  move_to_o,
  output logic [10:0] move_length_o,
  output logic        last_o
);

  typedef enum logic [20:0] {
    S_IDLE  = 21'b1 << 0,
    S_WREQ  = 21'b1 << 1,
    S_WCHK  = 21'b1 << 2,
    S_WFIT  = 21'b1 << 3,
    S_MREQ  = 21'b1 << 4,
    S_MCHK  = 21'b1 << 5,
    S_MEND  = 21'b1 << 6,
    S_D1REQ = 21'b1 << 7,
    S_D1CHK = 21'b1 << 8,
    S_D2REQ = 21'b1 << 9,
    S_D2CHK = 21'b1 << 10,
    S_D2WR  = 21'b1 << 11,
    S_D3    = 21'b1 << 12,
    S_D4REQ = 21'b1 << 13,
    S_D4CHK = 21'b1 << 14,
    S_DPOST = 21'b1 << 15,
    S_FIN   = 21'b1 << 16,
    S_FREQ  = 21'b1 << 17,
    S_FCHK  = 21'b1 << 18,
    S_CLR   = 21'b1 << 19,
    S_DONE  = 21'b1 << 20
  } state_e;

  localparam logic [SZW-1:0] RST_SIZE = SZW'(MAX_BLOCKS);

  state_e state_q, state_d;
  logic [PW-1:0]  p_q, p_d, q_q, q_d;
  logic [SZW-1:0] s_q, s_d, n_q, n_d;
  logic [SLW-1:0] sl_q, sl_d, i_q, i_d;
  logic [SCW-1:0] mv_cnt_q, mv_cnt_d;
  logic [SZW-1:0] tb_q, tb_d;
  logic [SCW-1:0] sc_q, sc_d;
  logic [SZW-1:0] used_q, used_d;
  logic           h0_wr_q, h0_wr_d;
  logic [AW-1:0]  slot_blk_q [MAX_SLOTS];
  logic [AW-1:0]  slot_blk_d [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] slot_used_q, slot_used_d;
  logic [2:0]     res_status_q, res_status_d;
  logic [SLW-1:0] res_slot_q, res_slot_d;
  logic [OFW-1:0] res_off_q, res_off_d;

  // header memory
  hdr_t          hdr_mem [MAX_BLOCKS];
  hdr_t          rdata_q, rhdr, wr_data;
  logic          rd_en, wr_en, rd_h0_q;
  logic [AW-1:0] rd_addr, wr_addr;

  // output register
  logic           out_valid_q;
  logic [2:0]     o_status_q;
  logic [SLW-1:0] o_slot_q;
  logic [OFW-1:0] o_off_q;
  logic           o_move_q, o_last_q;
  logic [AW-1:0]  o_from_q, o_to_q;
  logic [SZW-1:0] o_len_q;
  logic           can_load, emit_done, emit_move;

  logic [PW-1:0]  end_p, nxt, nxt_c;
  logic [SZW-1:0] n_in, tail;
  logic [14:0]    bytes_sum;
  logic [SLW-1:0] free_idx;
  logic           free_found;
  logic [10:0]    cfg_v;

  assign end_p     = {1'b0, tb_q};
  assign can_load  = !out_valid_q || out_ready_i;
  assign bytes_sum = {1'b0, alloc_bytes_i} + 15'(HEADER_BYTES + BLOCK_BYTES - 1);
  assign n_in      = SZW'(bytes_sum >> BSH);
  assign rhdr      = rd_h0_q ? hdr_t'{size: RST_SIZE, valid: 1'b0, slot: '0} : rdata_q;
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  // lowest empty slot below slot_count
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int k = MAX_SLOTS - 1; k >= 0; k--) begin
      if ((SCW'(k) < sc_q) && !slot_used_q[k]) begin
        free_idx   = SLW'(k);
        free_found = 1'b1;
      end
    end
  end

  function automatic logic [OFW-1:0] pay_off(logic [AW-1:0] b);
    return OFW'({b, {BSH{1'b0}}}) + OFW'(HEADER_BYTES);
  endfunction

  always_comb begin
    state_d      = state_q;
    p_d          = p_q;
    q_d          = q_q;
    s_d          = s_q;
    n_d          = n_q;
    sl_d         = sl_q;
    i_d          = i_q;
    mv_cnt_d     = mv_cnt_q;
    tb_d         = tb_q;
    sc_d         = sc_q;
    used_d       = used_q;
    slot_blk_d   = slot_blk_q;
    slot_used_d  = slot_used_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_off_d    = res_off_q;
    rd_en        = 1'b0;
    rd_addr      = p_q[AW-1:0];
    wr_en        = 1'b0;
    wr_addr      = p_q[AW-1:0];
    wr_data      = '0;
    emit_done    = 1'b0;
    emit_move    = 1'b0;
    nxt          = '0;
    nxt_c        = '0;
    tail         = '0;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TOTAL_BLOCKS: begin
          cfg_v = cfg_data_i;
          if (cfg_v == '0) cfg_v = 11'd1;
          if (cfg_v > 11'(MAX_BLOCKS)) cfg_v = 11'(MAX_BLOCKS);
          tb_d = SZW'(cfg_v);
        end
        CFG_SLOT_COUNT: begin
          cfg_v = {6'd0, cfg_data_i[4:0]};
          if (cfg_v == '0) cfg_v = 11'd1;
          if (cfg_v > 11'(MAX_SLOTS)) cfg_v = 11'(MAX_SLOTS);
          sc_d = SCW'(cfg_v);
        end
        default: cfg_v = '0;
      endcase
    end else begin
      cfg_v = '0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_status_d = ST_OK;
          res_slot_d   = '0;
          res_off_d    = '0;
          case (cmd_i)
            CMD_ALLOC: begin
              n_d = n_in;
              i_d = free_idx;
              p_d = '0;
              if (({1'b0, used_q} + {1'b0, n_in}) > {1'b0, tb_q}) begin
                res_status_d = ST_NO_SPACE;
                state_d      = S_DONE;
              end else if (!free_found) begin
                res_status_d = ST_NO_SLOT;
                state_d      = S_DONE;
              end else begin
                state_d = S_WREQ;
              end
            end
            CMD_CLEAR: begin
              q_d         = PW'(MAX_BLOCKS - 1);
              used_d      = '0;
              slot_used_d = '0;
              for (int k = 0; k < MAX_SLOTS; k++) slot_blk_d[k] = '0;
              state_d     = S_CLR;
            end
            default: begin
              res_slot_d = slot_id_i;
              if ((SCW'(slot_id_i) >= sc_q) || !slot_used_q[slot_id_i]) begin
                res_status_d = ST_BAD_SLOT;
                state_d      = S_DONE;
              end else if (cmd_i == CMD_LOCATE) begin
                res_off_d = pay_off(slot_blk_q[slot_id_i]);
                state_d   = S_DONE;
              end else begin
                p_d                    = PW'(slot_blk_q[slot_id_i]);
                slot_used_d[slot_id_i] = 1'b0;
                state_d                = S_FREQ;
              end
            end
          endcase
        end
      end

      // first-fit walk
      S_WREQ: begin
        if (p_q < end_p) begin
          rd_en   = 1'b1;
          rd_addr = p_q[AW-1:0];
          state_d = S_WCHK;
        end else begin
          p_d     = '0;
          state_d = S_D1REQ;
        end
      end
      S_WCHK: begin
        if (rhdr.size == '0) begin
          res_status_d = ST_CORRUPT;
          state_d      = S_DONE;
        end else if (rhdr.valid) begin
          p_d     = p_q + PW'(rhdr.size);
          state_d = S_WREQ;
        end else begin
          s_d = rhdr.size;
          if (rhdr.size < n_q) begin
            nxt     = p_q + PW'(rhdr.size);
            q_d     = (nxt > end_p) ? end_p : nxt;
            state_d = S_MREQ;
          end else begin
            state_d = S_WFIT;
          end
        end
      end
      S_WFIT: begin
        if (s_q == n_q) begin
          state_d = S_FIN;
        end else if (s_q > n_q) begin
          nxt = p_q + PW'(n_q);
          if (nxt < end_p) begin
            wr_en   = 1'b1;
            wr_addr = nxt[AW-1:0];
            wr_data = hdr_t'{size: s_q - n_q, valid: 1'b0, slot: '0};
          end
          state_d = S_FIN;
        end else begin
          p_d     = p_q + PW'(s_q);
          state_d = S_WREQ;
        end
      end

      // merge following free entries into the one at p
      S_MREQ: begin
        if (q_q < end_p) begin
          rd_en   = 1'b1;
          rd_addr = q_q[AW-1:0];
          state_d = S_MCHK;
        end else begin
          state_d = S_MEND;
        end
      end
      S_MCHK: begin
        if (!rhdr.valid && (rhdr.size != '0)) begin
          nxt     = q_q + PW'(rhdr.size);
          q_d     = (nxt > end_p) ? end_p : nxt;
          state_d = S_MREQ;
        end else begin
          state_d = S_MEND;
        end
      end
      S_MEND: begin
        nxt     = q_q - p_q;
        wr_en   = 1'b1;
        wr_addr = p_q[AW-1:0];
        wr_data = hdr_t'{size: SZW'(nxt), valid: 1'b0, slot: '0};
        s_d     = SZW'(nxt);
        state_d = S_WFIT;
      end

      // defrag: find first free entry (p = p1)
      S_D1REQ: begin
        if (p_q < end_p) begin
          rd_en   = 1'b1;
          rd_addr = p_q[AW-1:0];
          state_d = S_D1CHK;
        end else begin
          res_status_d = ST_CORRUPT;
          state_d      = S_DONE;
        end
      end
      S_D1CHK: begin
        if (rhdr.size == '0) begin
          res_status_d = ST_CORRUPT;
          state_d      = S_DONE;
        end else if (rhdr.valid) begin
          p_d     = p_q + PW'(rhdr.size);
          state_d = S_D1REQ;
        end else begin
          q_d      = p_q + PW'(rhdr.size);
          mv_cnt_d = '0;
          state_d  = S_D2REQ;
        end
      end
      // slide valid entries down (q = p2)
      S_D2REQ: begin
        if (q_q < end_p) begin
          rd_en   = 1'b1;
          rd_addr = q_q[AW-1:0];
          state_d = S_D2CHK;
        end else begin
          state_d = S_D3;
        end
      end
      S_D2CHK: begin
        if (rhdr.size == '0) begin
          res_status_d = ST_CORRUPT;
          state_d      = S_DONE;
        end else if (rhdr.valid) begin
          s_d     = rhdr.size;
          sl_d    = rhdr.slot;
          state_d = S_D2WR;
        end else begin
          q_d     = q_q + PW'(rhdr.size);
          state_d = S_D2REQ;
        end
      end
      S_D2WR: begin
        if (!(mv_cnt_q < SCW'(MAX_SLOTS)) || can_load) begin
          if (mv_cnt_q < SCW'(MAX_SLOTS)) begin
            emit_move = 1'b1;
            mv_cnt_d  = mv_cnt_q + 1'b1;
          end
          wr_en   = 1'b1;
          wr_addr = p_q[AW-1:0];
          wr_data = hdr_t'{size: s_q, valid: 1'b1, slot: sl_q};
          p_d     = p_q + PW'(s_q);
          q_d     = q_q + PW'(s_q);
          state_d = S_D2REQ;
        end
      end
      S_D3: begin
        if (p_q < end_p) begin
          nxt     = end_p - p_q;
          wr_en   = 1'b1;
          wr_addr = p_q[AW-1:0];
          wr_data = hdr_t'{size: SZW'(nxt), valid: 1'b0, slot: '0};
        end
        q_d     = '0;
        state_d = S_D4REQ;
      end
      // rebuild slot table from the header chain
      S_D4REQ: begin
        if (q_q < end_p) begin
          rd_en   = 1'b1;
          rd_addr = q_q[AW-1:0];
          state_d = S_D4CHK;
        end else begin
          state_d = S_DPOST;
        end
      end
      S_D4CHK: begin
        if (rhdr.size == '0) begin
          state_d = S_DPOST;
        end else begin
          if (rhdr.valid) slot_blk_d[rhdr.slot] = q_q[AW-1:0];
          q_d     = q_q + PW'(rhdr.size);
          state_d = S_D4REQ;
        end
      end
      S_DPOST: begin
        tail = SZW'(end_p - p_q);
        if ((p_q >= end_p) || (tail < n_q)) begin
          res_status_d = ST_CORRUPT;
          state_d      = S_DONE;
        end else begin
          if (tail > n_q) begin
            nxt_c   = p_q + PW'(n_q);
            wr_en   = 1'b1;
            wr_addr = nxt_c[AW-1:0];
            wr_data = hdr_t'{size: tail - n_q, valid: 1'b0, slot: '0};
          end
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        wr_en             = 1'b1;
        wr_addr           = p_q[AW-1:0];
        wr_data           = hdr_t'{size: n_q, valid: 1'b1, slot: i_q};
        slot_blk_d[i_q]   = p_q[AW-1:0];
        slot_used_d[i_q]  = 1'b1;
        used_d            = used_q + n_q;
        res_status_d      = ST_OK;
        res_slot_d        = i_q;
        res_off_d         = pay_off(p_q[AW-1:0]);
        state_d           = S_DONE;
      end

      // free: clear the header valid bit
      S_FREQ: begin
        rd_en   = 1'b1;
        rd_addr = p_q[AW-1:0];
        state_d = S_FCHK;
      end
      S_FCHK: begin
        wr_en   = 1'b1;
        wr_addr = p_q[AW-1:0];
        wr_data = hdr_t'{size: rhdr.size, valid: 1'b0, slot: rhdr.slot};
        used_d  = (used_q > rhdr.size) ? used_q - rhdr.size : '0;
        state_d = S_DONE;
      end

      S_CLR: begin
        wr_en   = 1'b1;
        wr_addr = q_q[AW-1:0];
        if (q_q == '0) begin
          wr_data = hdr_t'{size: tb_q, valid: 1'b0, slot: '0};
          state_d = S_DONE;
        end else begin
          wr_data = '0;
          q_d     = q_q - 1'b1;
        end
      end

      S_DONE: begin
        if (can_load) begin
          emit_done = 1'b1;
          state_d   = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    h0_wr_d = h0_wr_q || (wr_en && (wr_addr == '0));
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) hdr_mem[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= hdr_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_h0_q <= 1'b0;
    end else if (rd_en) begin
      rd_h0_q <= (rd_addr == '0) && !h0_wr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tb_q        <= SZW'(MAX_BLOCKS);
      sc_q        <= SCW'(MAX_SLOTS);
      used_q      <= '0;
      h0_wr_q     <= 1'b0;
      slot_used_q <= '0;
      mv_cnt_q    <= '0;
      for (int k = 0; k < MAX_SLOTS; k++) slot_blk_q[k] <= '0;
    end else begin
      state_q     <= state_d;
      tb_q        <= tb_d;
      sc_q        <= sc_d;
      used_q      <= used_d;
      h0_wr_q     <= h0_wr_d;
      slot_used_q <= slot_used_d;
      mv_cnt_q    <= mv_cnt_d;
      slot_blk_q  <= slot_blk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q          <= p_d;
    q_q          <= q_d;
    s_q          <= s_d;
    n_q          <= n_d;
    sl_q         <= sl_d;
    i_q          <= i_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_off_q    <= res_off_d;
  end

  // result beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_done || emit_move) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_move) begin
      o_status_q <= ST_OK;
      o_slot_q   <= i_q;
      o_off_q    <= '0;
      o_move_q   <= 1'b1;
      o_from_q   <= q_q[AW-1:0];
      o_to_q     <= p_q[AW-1:0];
      o_len_q    <= s_q;
      o_last_q   <= 1'b0;
    end else if (emit_done) begin
      o_status_q <= res_status_q;
      o_slot_q   <= res_slot_q;
      o_off_q    <= res_off_q;
      o_move_q   <= 1'b0;
      o_from_q   <= '0;
      o_to_q     <= '0;
      o_len_q    <= '0;
      o_last_q   <= 1'b1;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = o_status_q;
  assign result_slot_o    = o_slot_q;
  assign payload_offset_o = o_off_q;
  assign is_move_o        = o_move_q;
  assign move_from_o      = o_from_q;
  assign move_to_o        = o_to_q;
  assign move_length_o    = o_len_q;
  assign last_o           = o_last_q;

endmodule

>>> rtl/csba_checker.sv
// ----------------------------------------------------------------------------
// csba_checker
// Port-level checks for the compacting slot block allocator.
// ----------------------------------------------------------------------------
module csba_checker
  import csba_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic        is_move_o,
  input logic [10:0] move_length_o,
  input logic        last_o
);

  // a move beat is never the closing beat and always reports ok
  a_move_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_move_o |-> !last_o && (status_o == ST_OK))
    else $error("move beat flagged last or not ok");

  a_last_no_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> (move_length_o == '0))
    else $error("closing beat carries move length");

  // one command at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after accepting a command");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(last_o))
    else $error("result beat changed while stalled");

endmodule

bind compacting_slot_block_allocator csba_checker u_csba_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .status_o      (status_o),
  .is_move_o     (is_move_o),
  .move_length_o (move_length_o),
  .last_o        (last_o)
);

>>> dv/compacting_slot_block_allocator_tb.sv
// ----------------------------------------------------------------------------
// compacting_slot_block_allocator_tb
// Drives alloc/free/locate/clear commands and register writes into the block
// allocator. Every result beat, move orders included, is checked against a
// behavioral model of the header walk, merge, split and defragmentation.
// ----------------------------------------------------------------------------
module compacting_slot_block_allocator_tb
  import csba_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WDOG_LIMIT = 100000;
  localparam int unsigned SETTLE     = 20;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [10:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  cmd_i = '0;
  logic [13:0] alloc_bytes_i = '0;
  logic [3:0]  slot_id_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [3:0]  result_slot_o;
  logic [13:0] payload_offset_o;
  logic        is_move_o;
  logic [9:0]  move_from_o;
  logic [9:0]  move_to_o;
  logic [10:0] move_length_o;
  logic        last_o;

  compacting_slot_block_allocator u_top (.*);

  always #6 clk_i = ~clk_i;

  typedef struct {
    logic [2:0]  st;
    logic [3:0]  sl;
    logic [13:0] off;
    logic        mv;
    logic [9:0]  from;
    logic [9:0]  to;
    logic [10:0] len;
    logic        lst;
  } beat_t;

  // directed stimulus row: a register write or a command, optionally typed result
  typedef struct {
    bit          is_cfg;
    cfg_idx_e    idx;
    int unsigned data;
    cmd_e        cmd;
    int unsigned bytes;
    int unsigned slot;
    bit          chk;
    status_e     st;
    int unsigned sl;
    int unsigned off;
  } row_t;

  beat_t       result_q[$];
  row_t        dir_tab[$];
  int unsigned err_cnt = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_cyc = 0;
  int unsigned wdog = 0;

  // allocator image
  int unsigned hdr_size [MAX_BLOCKS];
  bit          hdr_valid[MAX_BLOCKS];
  int unsigned hdr_slot [MAX_BLOCKS];
  int unsigned tbl_block[MAX_SLOTS];
  bit          tbl_used [MAX_SLOTS];
  int unsigned used_blk;
  int unsigned total_blk;
  int unsigned num_slots;

  function automatic void push_final(status_e st, int unsigned sl, int unsigned off);
    beat_t b;
    b = '{st: st, sl: sl[3:0], off: off[13:0], mv: 1'b0, from: '0, to: '0, len: '0,
          lst: 1'b1};
    result_q.push_back(b);
  endfunction

  function automatic void push_move(int unsigned sl, int unsigned fr, int unsigned to,
                                    int unsigned len);
    beat_t b;
    b = '{st: ST_OK, sl: sl[3:0], off: '0, mv: 1'b1, from: fr[9:0], to: to[9:0],
          len: len[10:0], lst: 1'b0};
    result_q.push_back(b);
  endfunction

  function automatic void wipe_buffer();
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      hdr_size[i] = 0; hdr_valid[i] = 0; hdr_slot[i] = 0;
    end
    for (int i = 0; i < MAX_SLOTS; i++) begin
      tbl_block[i] = 0; tbl_used[i] = 0;
    end
    used_blk = 0;
    hdr_size[0] = total_blk;
  endfunction

  function automatic void absorb_free(int unsigned p, int unsigned lim);
    int unsigned q;
    bit          grew;
    q = p;
    grew = 0;
    while (q < lim && !hdr_valid[q] && hdr_size[q] != 0) begin
      q += hdr_size[q];
      if (q > lim) q = lim;
      grew = 1;
    end
    if (grew) hdr_size[p] = q - p;
  endfunction

  // slide valid entries down; returns first free block or lim on failure
  function automatic int unsigned compact(int unsigned slot, int unsigned lim);
    int unsigned p1, p2, s, moves, q;
    p1 = 0;
    moves = 0;
    while (p1 < lim && hdr_valid[p1]) begin
      s = hdr_size[p1];
      if (s == 0) return lim;
      p1 += s;
    end
    if (p1 >= lim) return lim;
    s = hdr_size[p1];
    if (s == 0) return lim;
    p2 = p1 + s;
    while (p2 < lim) begin
      s = hdr_size[p2];
      if (s == 0) return lim;
      if (hdr_valid[p2]) begin
        if (moves < MAX_SLOTS) begin
          push_move(slot, p2, p1, s);
          moves++;
        end
        hdr_size[p1] = s;
        hdr_valid[p1] = 1;
        hdr_slot[p1] = hdr_slot[p2];
        p1 += s;
      end
      p2 += s;
    end
    if (p1 < lim) begin
      hdr_size[p1] = lim - p1;
      hdr_valid[p1] = 0;
    end
    q = 0;
    while (q < lim) begin
      s = hdr_size[q];
      if (s == 0) break;
      if (hdr_valid[q] && hdr_slot[q] < MAX_SLOTS) tbl_block[hdr_slot[q]] = q;
      q += s;
    end
    return (p1 < lim) ? p1 : lim;
  endfunction

  function automatic void predict_alloc(int unsigned bytes);
    int unsigned lim, n, i, p, s;
    bit          found;
    lim = total_blk;
    n = (bytes + HEADER_BYTES + BLOCK_BYTES - 1) / BLOCK_BYTES;
    found = 0;
    if (used_blk + n > lim) begin
      push_final(ST_NO_SPACE, 0, 0);
      return;
    end
    for (i = 0; i < num_slots; i++) if (!tbl_used[i]) break;
    if (i >= num_slots) begin
      push_final(ST_NO_SLOT, 0, 0);
      return;
    end
    p = 0;
    while (p < lim) begin
      s = hdr_size[p];
      if (s == 0) begin
        push_final(ST_CORRUPT, 0, 0);
        return;
      end
      if (!hdr_valid[p]) begin
        if (s < n) begin
          absorb_free(p, lim);
          s = hdr_size[p];
        end
        if (s == n) begin
          found = 1;
          break;
        end
        if (s > n) begin
          if (p + n < lim) begin
            hdr_size[p+n] = s - n; hdr_valid[p+n] = 0; hdr_slot[p+n] = 0;
          end
          found = 1;
          break;
        end
      end
      p += s;
    end
    if (!found) begin
      p = compact(i, lim);
      if (p >= lim) begin
        push_final(ST_CORRUPT, 0, 0);
        return;
      end
      s = hdr_size[p];
      if (s < n) begin
        push_final(ST_CORRUPT, 0, 0);
        return;
      end
      if (s > n) begin
        hdr_size[p+n] = s - n; hdr_valid[p+n] = 0; hdr_slot[p+n] = 0;
      end
    end
    hdr_size[p] = n;
    hdr_valid[p] = 1;
    hdr_slot[p] = i;
    tbl_block[i] = p;
    tbl_used[i] = 1;
    used_blk += n;
    push_final(ST_OK, i, p * BLOCK_BYTES + HEADER_BYTES);
  endfunction

  function automatic void predict_cmd(cmd_e cmd, int unsigned bytes, int unsigned id);
    int unsigned b, s;
    if (cmd == CMD_ALLOC) begin
      predict_alloc(bytes);
    end else if (cmd == CMD_CLEAR) begin
      wipe_buffer();
      push_final(ST_OK, 0, 0);
    end else if (id >= num_slots || !tbl_used[id]) begin
      push_final(ST_BAD_SLOT, id, 0);
    end else begin
      b = tbl_block[id];
      if (cmd == CMD_LOCATE) begin
        push_final(ST_OK, id, b * BLOCK_BYTES + HEADER_BYTES);
      end else begin
        tbl_used[id] = 0;
        hdr_valid[b] = 0;
        s = hdr_size[b];
        used_blk = (used_blk > s) ? used_blk - s : 0;
        push_final(ST_OK, id, 0);
      end
    end
  endfunction

  task automatic report(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    beat_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (result_q.size() == 0) begin
        report("unexpected beat, status", status_o, 0);
      end else begin
        e = result_q.pop_front();
        if (status_o != e.st) report("status", status_o, e.st);
        if (result_slot_o != e.sl) report("result_slot", result_slot_o, e.sl);
        if (payload_offset_o != e.off) report("payload_offset", payload_offset_o, e.off);
        if (is_move_o != e.mv) report("is_move", is_move_o, e.mv);
        if (move_from_o != e.from) report("move_from", move_from_o, e.from);
        if (move_to_o != e.to) report("move_to", move_to_o, e.to);
        if (move_length_o != e.len) report("move_length", move_length_o, e.len);
        if (last_o != e.lst) report("last", last_o, e.lst);
      end
    end
  end

  // receiver; a pending hold forces a long stall
  always @(posedge clk_i) begin
    if (hold_cyc > 0) begin
      hold_cyc <= hold_cyc - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      wdog <= 0;
    end else if (wdog >= WDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      wdog <= wdog + 1;
    end
  end

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int unsigned data);
    int unsigned v;
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data[10:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_TOTAL_BLOCKS) begin
      v = data & 'h7FF;
      total_blk = (v < 1) ? 1 : (v > MAX_BLOCKS) ? MAX_BLOCKS : v;
    end else begin
      v = data & 'h1F;
      num_slots = (v < 1) ? 1 : (v > MAX_SLOTS) ? MAX_SLOTS : v;
    end
  endtask

  task automatic send(cmd_e cmd, int unsigned bytes, int unsigned id);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= cmd;
    alloc_bytes_i <= bytes[13:0];
    slot_id_i     <= id[3:0];
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_cmd(cmd, bytes, id);
  endtask

  function automatic int unsigned pick_slot();
    int unsigned live[$];
    for (int i = 0; i < MAX_SLOTS; i++) if (tbl_used[i]) live.push_back(i);
    if (live.size() != 0 && $urandom_range(3) != 0)
      return live[$urandom_range(live.size() - 1)];
    return $urandom_range(15);
  endfunction

  function automatic int unsigned pick_bytes();
    int unsigned r, top;
    r = $urandom_range(99);
    top = total_blk * 4;
    if (top > 16383) top = 16383;
    if (r < 70) return $urandom_range(top);
    if (r < 85) return $urandom_range(63);
    return $urandom_range(16383);
  endfunction

  function automatic void row_c(cmd_e cmd, int unsigned bytes, int unsigned slot);
    dir_tab.push_back('{0, CFG_TOTAL_BLOCKS, 0, cmd, bytes, slot, 0, ST_OK, 0, 0});
  endfunction

  function automatic void row_x(cmd_e cmd, int unsigned bytes, int unsigned slot,
                                status_e st, int unsigned sl, int unsigned off);
    dir_tab.push_back('{0, CFG_TOTAL_BLOCKS, 0, cmd, bytes, slot, 1, st, sl, off});
  endfunction

  function automatic void row_w(cfg_idx_e idx, int unsigned data);
    dir_tab.push_back('{1, idx, data, CMD_ALLOC, 0, 0, 0, ST_OK, 0, 0});
  endfunction

  initial begin
    int unsigned ph_total[5] = '{1024, 40, 0, 64, 2047};
    int unsigned ph_slots[5] = '{16, 31, 0, 4, 16};
    int unsigned ph_idle [5] = '{0, 73, 0, 28, 73};
    int unsigned ph_stall[5] = '{0, 0, 73, 28, 73};
    int unsigned r;
    cmd_e        c;

    total_blk = MAX_BLOCKS;
    num_slots = MAX_SLOTS;
    wipe_buffer();

    row_x(CMD_ALLOC,  0,     0,  ST_OK,       0,  HEADER_BYTES);
    row_x(CMD_LOCATE, 0,     0,  ST_OK,       0,  HEADER_BYTES);
    row_x(CMD_FREE,   0,     15, ST_BAD_SLOT, 15, 0);
    row_x(CMD_ALLOC,  16383, 0,  ST_NO_SPACE, 0,  0);
    row_x(CMD_FREE,   0,     0,  ST_OK,       0,  0);
    row_x(CMD_LOCATE, 0,     0,  ST_BAD_SLOT, 0,  0);
    // merges the two free pieces back into one exact fit
    row_x(CMD_ALLOC,  16380, 0,  ST_OK,       0,  HEADER_BYTES);
    row_x(CMD_ALLOC,  0,     0,  ST_NO_SPACE, 0,  0);
    row_x(CMD_CLEAR,  0,     0,  ST_OK,       0,  0);
    // tiny buffer, fragment it, then force a defrag with two moves
    row_w(CFG_TOTAL_BLOCKS, 6);
    row_c(CMD_CLEAR,  0,  0);
    row_c(CMD_ALLOC,  12, 0);
    row_c(CMD_ALLOC,  12, 0);
    row_c(CMD_ALLOC,  12, 0);
    row_c(CMD_ALLOC,  44, 0);
    row_c(CMD_FREE,   0,  0);
    row_c(CMD_FREE,   0,  2);
    row_c(CMD_ALLOC,  28, 0);
    row_w(CFG_SLOT_COUNT, 0);
    // buffer is full, so the space check wins over the slot check
    row_x(CMD_ALLOC,  0,  0,  ST_NO_SPACE, 0, 0);
    row_x(CMD_LOCATE, 0,  5,  ST_BAD_SLOT, 5, 0);
    row_c(CMD_LOCATE, 0,  0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[k]) begin
      if (dir_tab[k].is_cfg) begin
        write_reg(dir_tab[k].idx, dir_tab[k].data);
      end else begin
        send(dir_tab[k].cmd, dir_tab[k].bytes, dir_tab[k].slot);
        if (dir_tab[k].chk) begin
          result_q[$].st  = dir_tab[k].st;
          result_q[$].sl  = dir_tab[k].sl[3:0];
          result_q[$].off = dir_tab[k].off[13:0];
        end
      end
    end

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_TOTAL_BLOCKS, ph_total[ph]);
      write_reg(CFG_SLOT_COUNT, ph_slots[ph]);
      idle_pct  = ph_idle[ph];
      stall_pct = ph_stall[ph];
      // headers beyond the old end may be stale, so start from a clean buffer
      send(CMD_CLEAR, $urandom_range(16383), $urandom_range(15));
      if (ph == 1) hold_cyc = 400;
      for (int n = 0; n < 40; n++) begin
        r = $urandom_range(99);
        c = (r < 55) ? CMD_ALLOC : (r < 80) ? CMD_FREE : (r < 96) ? CMD_LOCATE : CMD_CLEAR;
        send(c, (c == CMD_ALLOC) ? pick_bytes() : $urandom_range(16383), pick_slot());
      end
      // shrink the buffer under live entries without clearing
      if (ph == 3) begin
        write_reg(CFG_TOTAL_BLOCKS, 20);
        for (int n = 0; n < 10; n++)
          send($urandom_range(2) == 0 ? CMD_FREE : CMD_ALLOC, $urandom_range(40), pick_slot());
      end
    end

    drain();
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/csba_pkg.sv
rtl/compacting_slot_block_allocator.sv
rtl/csba_checker.sv
dv/compacting_slot_block_allocator_tb.sv
